// ===== design/fcpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fcpa_pkg: shared types and codes for the fixed chunk pool allocator
// Request and response payloads, request and status codes, register
// indexes, and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package fcpa_pkg;

    // Field widths fixed by the interface
    localparam int ADDR_W  = 32;
    localparam int SIZE_W  = 17;
    localparam int COUNT_W = 9;
    localparam int BYTES_W = 25;
    localparam int CFG_W   = 32;

    localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

    // Request codes
    localparam logic [1:0] REQ_ALLOC  = 2'd0;
    localparam logic [1:0] REQ_FREE   = 2'd1;
    localparam logic [1:0] REQ_REINIT = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_SIZE     = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_BASE  = 2'd0;
    localparam logic [1:0] CFG_SIZE  = 2'd1;
    localparam logic [1:0] CFG_COUNT = 2'd2;

    // Configuration reset values
    localparam logic [ADDR_W-1:0]  BASE_RST  = 32'd0;
    localparam logic [SIZE_W-1:0]  SIZE_RST  = 17'd64;
    localparam logic [COUNT_W-1:0] COUNT_RST = 9'd256;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] release_address;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  granted_address;
        logic [1:0]         status;
        logic [BYTES_W-1:0] bytes_in_use;
        logic [BYTES_W-1:0] peak_bytes;
    } rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FILL,
        S_RESP
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic fill;
        logic load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic fill_start;
        logic fill_last;
        logic out_free;
    } stat_t;

endpackage

// ===== design/fcpa_ram.sv =====
// ----------------------------------------------------------------------------
// fcpa_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fcpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/fcpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// fcpa_ctrl: sequencing state machine
// Accepts one request at a time, runs the refill sweep after a reinit,
// and loads the response register once it has room.
// ----------------------------------------------------------------------------
module fcpa_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  fcpa_pkg::stat_t stat,
    output fcpa_pkg::cmd_t  cmd
);

    fcpa_pkg::state_t state_reg;
    fcpa_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fcpa_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        req_ready  = 1'b0;
        cmd        = '0;
        case (state_reg)
            fcpa_pkg::S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = stat.fill_start ? fcpa_pkg::S_FILL : fcpa_pkg::S_RESP;
                end
            end
            fcpa_pkg::S_FILL:
            begin
                cmd.fill = 1'b1;
                if (stat.fill_last)
                begin
                    state_next = fcpa_pkg::S_RESP;
                end
            end
            fcpa_pkg::S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = fcpa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fcpa_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/fcpa_dp.sv =====
// ----------------------------------------------------------------------------
// fcpa_dp: allocator datapath
// Configuration registers, free stack memory and pointer, byte counters,
// refill address generator and the response register.
// ----------------------------------------------------------------------------
module fcpa_dp #(
    parameter int NUM_CHUNKS = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [1:0]                 cfg_index,
    input  logic [fcpa_pkg::CFG_W-1:0] cfg_data,
    input  fcpa_pkg::req_t             req_data,
    input  fcpa_pkg::cmd_t             cmd,
    output fcpa_pkg::stat_t            stat,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output fcpa_pkg::rsp_t             rsp_data
);

    localparam int AW = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int DW = $clog2(NUM_CHUNKS + 1);
    localparam int CW = (DW > fcpa_pkg::COUNT_W) ? DW : fcpa_pkg::COUNT_W;
    localparam int BW = fcpa_pkg::BYTES_W;

    // Configuration
    logic [fcpa_pkg::ADDR_W-1:0]  base_reg;
    logic [fcpa_pkg::SIZE_W-1:0]  size_reg;
    logic [fcpa_pkg::COUNT_W-1:0] count_reg;

    // Pool state
    logic [DW-1:0] depth_reg, depth_next;
    logic [BW-1:0] used_reg, used_next;
    logic [BW-1:0] peak_reg, peak_next;

    // Refill sweep
    logic [DW-1:0]               fill_idx_reg, fill_idx_next;
    logic [DW-1:0]               fill_n_reg, fill_n_next;
    logic [fcpa_pkg::ADDR_W-1:0] fill_addr_reg, fill_addr_next;

    // Pending result
    logic [1:0] status_reg, status_next;
    logic       gnt_reg, gnt_next;
    logic       rsp_valid_reg, rsp_valid_next;
    fcpa_pkg::rsp_t rsp_reg;

    // Memory ports
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [fcpa_pkg::ADDR_W-1:0] wr_data;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic [fcpa_pkg::ADDR_W-1:0] rd_data;

    logic [CW-1:0] count_w;
    logic [DW-1:0] count_sat;
    logic [BW:0]   used_sum;
    logic [BW-1:0] used_inc;
    logic [BW-1:0] size_ext;
    logic [DW-1:0] depth_dec;

    fcpa_ram #(
        .WIDTH(fcpa_pkg::ADDR_W),
        .DEPTH(NUM_CHUNKS)
    ) u_stack (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // Clamp chunk count to the stack depth
    assign count_w   = CW'(count_reg);
    assign count_sat = (count_w > CW'(NUM_CHUNKS)) ? DW'(NUM_CHUNKS) : DW'(count_w);

    // Saturating add of one chunk
    assign size_ext  = BW'(size_reg);
    assign used_sum  = {1'b0, used_reg} + {1'b0, size_ext};
    assign used_inc  = used_sum[BW] ? fcpa_pkg::BYTES_MAX : used_sum[BW-1:0];
    assign depth_dec = depth_reg - DW'(1);

    // Status toward the controller
    always_comb
    begin
        stat.fill_start = (req_data.req_type == fcpa_pkg::REQ_REINIT) && (count_sat != '0);
        stat.fill_last  = ((fill_idx_reg + DW'(1)) == fill_n_reg);
        stat.out_free   = !rsp_valid_reg || rsp_ready;
    end

    // Request execution, refill sweep and response handshake
    always_comb
    begin
        depth_next     = depth_reg;
        used_next      = used_reg;
        peak_next      = peak_reg;
        fill_idx_next  = fill_idx_reg;
        fill_n_next    = fill_n_reg;
        fill_addr_next = fill_addr_reg;
        status_next    = status_reg;
        gnt_next       = gnt_reg;
        wr_en          = 1'b0;
        wr_addr        = depth_reg[AW-1:0];
        wr_data        = req_data.release_address;
        rd_en          = 1'b0;
        rd_addr        = depth_dec[AW-1:0];

        if (cmd.accept)
        begin
            status_next = fcpa_pkg::ST_OK;
            gnt_next    = 1'b0;
            case (req_data.req_type)
                fcpa_pkg::REQ_ALLOC:
                begin
                    if (req_data.request_size != size_reg)
                    begin
                        status_next = fcpa_pkg::ST_SIZE;
                    end
                    else if (depth_reg == '0)
                    begin
                        status_next = fcpa_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        // Pop the top entry
                        rd_en      = 1'b1;
                        gnt_next   = 1'b1;
                        depth_next = depth_dec;
                        used_next  = used_inc;
                        peak_next  = (used_inc > peak_reg) ? used_inc : peak_reg;
                    end
                end
                fcpa_pkg::REQ_FREE:
                begin
                    if (depth_reg == DW'(NUM_CHUNKS))
                    begin
                        status_next = fcpa_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        // Push the returned address
                        wr_en      = 1'b1;
                        depth_next = depth_reg + DW'(1);
                        used_next  = (used_reg > size_ext) ? (used_reg - size_ext) : '0;
                    end
                end
                fcpa_pkg::REQ_REINIT:
                begin
                    depth_next     = '0;
                    used_next      = '0;
                    peak_next      = '0;
                    fill_idx_next  = '0;
                    fill_n_next    = count_sat;
                    fill_addr_next = base_reg;
                end
                default:
                begin
                    status_next = fcpa_pkg::ST_OK;
                end
            endcase
        end
        else if (cmd.fill)
        begin
            // Write one chunk address per cycle
            wr_en          = 1'b1;
            wr_addr        = fill_idx_reg[AW-1:0];
            wr_data        = fill_addr_reg;
            fill_idx_next  = fill_idx_reg + DW'(1);
            fill_addr_next = fill_addr_reg + fcpa_pkg::ADDR_W'(size_reg);
            if (stat.fill_last)
            begin
                depth_next = fill_n_reg;
            end
        end

        rsp_valid_next = rsp_valid_reg;
        if (cmd.load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= fcpa_pkg::BASE_RST;
            size_reg  <= fcpa_pkg::SIZE_RST;
            count_reg <= fcpa_pkg::COUNT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                fcpa_pkg::CFG_BASE:  base_reg  <= cfg_data;
                fcpa_pkg::CFG_SIZE:  size_reg  <= cfg_data[fcpa_pkg::SIZE_W-1:0];
                fcpa_pkg::CFG_COUNT: count_reg <= cfg_data[fcpa_pkg::COUNT_W-1:0];
                default:             base_reg  <= base_reg;
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= '0;
            used_reg      <= '0;
            peak_reg      <= '0;
            fill_idx_reg  <= '0;
            fill_n_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            depth_reg     <= depth_next;
            used_reg      <= used_next;
            peak_reg      <= peak_next;
            fill_idx_reg  <= fill_idx_next;
            fill_n_reg    <= fill_n_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        fill_addr_reg <= fill_addr_next;
        status_reg    <= status_next;
        gnt_reg       <= gnt_next;
        if (cmd.load)
        begin
            rsp_reg.granted_address <= gnt_reg ? rd_data : '0;
            rsp_reg.status          <= status_reg;
            rsp_reg.bytes_in_use    <= used_reg;
            rsp_reg.peak_bytes      <= peak_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule

// ===== design/fixed_chunk_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// fixed_chunk_pool_allocator: fixed-size chunk pool with a LIFO free list
// Hands out and takes back equal-sized chunk addresses and tracks the
// bytes in use and their peak since the last reinit.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req_data) carries allocate, free and
//   reinit requests; rsp channel (rsp_valid/rsp_ready/rsp_data) returns one
//   response per request, in order. Registers are written through
//   cfg_wr_en/cfg_index/cfg_data while no request is in flight.
//   Allocate and free execute on the accept edge (one stack memory access);
//   the response register then loads once it is free, and the next request
//   can be taken after that. Reinit first refills n = min(chunk_count,
//   NUM_CHUNKS) stack entries, one entry per cycle through the single write
//   port, then loads its response the same way.
//   The response register is separate from the request side: a stalled
//   response holds, and one further request is executed meanwhile; its
//   response waits until the register frees, and req_ready stays low.
//   After reset the pool is empty, both byte counters are zero and the
//   registers hold base 0, chunk size 64 and chunk count 256; issue a
//   reinit before allocating.
// ----------------------------------------------------------------------------
module fixed_chunk_pool_allocator #(
    parameter int NUM_CHUNKS = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [1:0]                 cfg_index,
    input  logic [fcpa_pkg::CFG_W-1:0] cfg_data,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  fcpa_pkg::req_t             req_data,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output fcpa_pkg::rsp_t             rsp_data
);

    fcpa_pkg::cmd_t  cmd;
    fcpa_pkg::stat_t stat;

    fcpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fcpa_dp #(
        .NUM_CHUNKS(NUM_CHUNKS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .req_data (req_data),
        .cmd      (cmd),
        .stat     (stat),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp_data (rsp_data)
    );

`ifndef SYNTH
    // One request in flight: no accept on the cycle after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted back to back");

    // Failed requests never grant an address
    a_fail_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status != fcpa_pkg::ST_OK |-> rsp_data.granted_address == '0)
        else $error("address granted on a failed request");

    // Peak never trails the bytes in use
    a_peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_data.peak_bytes >= rsp_data.bytes_in_use)
        else $error("peak below bytes in use");
`endif

endmodule
